/* sv/gvn_pkg.sv */
// ----------------------------------------------------------------------------
// gvn_pkg: shared types and constants of the grid vertex normal generator
// Item layouts, the front-to-back job record and command codes.
// ----------------------------------------------------------------------------
package gvn_pkg;

    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    localparam int CFG_W = 9;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               degenerate;
        logic               grid_done;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } t_vec33;

    typedef struct packed {
        logic signed [30:0] x;
        logic signed [30:0] y;
        logic signed [30:0] z;
    } t_vec31;

    // one finished neighbor gather, handed from front to back
    typedef struct packed {
        t_pos   p;
        t_vec33 dx;
        t_vec33 dz;
        logic   done;
    } t_job;

endpackage

/* sv/gvn_fifo.sv */
// ----------------------------------------------------------------------------
// gvn_fifo: small register queue
// Push/full on the write side, pop/empty on the read side.
// ----------------------------------------------------------------------------
module gvn_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_wr) - CW'(w_rd);
        end
    end

endmodule

/* sv/gvn_front.sv */
// ----------------------------------------------------------------------------
// gvn_front: item intake, row store and neighbor gather
// Classify items, write vertices to the three-row store, read the five
// positions a pending result needs and hand the differences to the back.
// ----------------------------------------------------------------------------
module gvn_front #(
    parameter int MAX_GRID = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [gvn_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                     i_push,
    output logic                     o_full,
    input  gvn_pkg::t_in_item        i_in,
    output logic                     o_job_push,
    output gvn_pkg::t_job            o_job,
    input  logic                     i_job_full
);
    localparam int XW       = $clog2(MAX_GRID);
    localparam int DEPTH    = 3 * MAX_GRID;
    localparam int AW       = $clog2(DEPTH);
    localparam int RST_SIZE = (MAX_GRID < 256) ? MAX_GRID : 256;
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_GRID);

    localparam logic [2:0] NB_P = 3'd0;
    localparam logic [2:0] NB_R = 3'd1;
    localparam logic [2:0] NB_L = 3'd2;
    localparam logic [2:0] NB_D = 3'd3;
    localparam logic [2:0] NB_U = 3'd4;
    localparam logic [2:0] NB_N = 3'd5;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_READ = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

    function automatic logic [1:0] fn_slot_next(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [1:0] fn_slot_prev(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    function automatic logic [AW-1:0] fn_addr(input logic [1:0] s, input logic [XW-1:0] x);
        return AW'(s) * ROW_STRIDE + AW'(x);
    endfunction

    t_front_state   r_state, n_state;
    logic [XW-1:0]  r_last, n_last;
    logic [XW-1:0]  r_xi, r_zi, r_xo, r_zo;
    logic [1:0]     r_si, r_so;
    logic           r_fi, r_fo;
    logic [2:0]     r_rc;
    gvn_pkg::t_pos  r_nb [5];
    gvn_pkg::t_pos  r_mem [DEPTH];
    gvn_pkg::t_pos  r_rdata;

    logic           w_acc, w_drain, w_pend, w_emit, w_vert, w_cfg;
    logic [XW-1:0]  w_wx, w_wz;
    logic [1:0]     w_ws;
    logic [AW-1:0]  w_addr;
    logic [XW-1:0]  w_xr, w_xl;
    logic [1:0]     w_sd, w_su;

    assign o_full      = (r_state != F_IDLE);
    // hold a register write while an item is offered so neither is lost
    assign o_cfg_ready = (r_state == F_IDLE) && !i_push;
    assign w_cfg       = i_cfg_valid && o_cfg_ready;
    assign w_acc       = i_push && !o_full;
    assign w_drain     = (i_in.cmd == gvn_pkg::CMD_DRAIN);
    assign w_pend      = r_fi && !r_fo;
    assign w_vert      = w_acc && !w_drain && !w_pend;
    // restart the grid when a vertex follows a complete, drained grid
    assign w_wx        = r_fi ? '0 : r_xi;
    assign w_wz        = r_fi ? '0 : r_zi;
    assign w_ws        = r_fi ? 2'd0 : r_si;
    assign w_emit      = (w_acc && w_drain && w_pend) || (w_vert && (w_wz != '0));

    // clamped neighbor coordinates
    assign w_xr = (r_xo == r_last) ? r_xo : r_xo + 1'b1;
    assign w_xl = (r_xo == '0) ? r_xo : r_xo - 1'b1;
    assign w_sd = (r_zo == r_last) ? r_so : fn_slot_next(r_so);
    assign w_su = (r_zo == '0) ? r_so : fn_slot_prev(r_so);

    always_comb begin
        int eff;
        eff = int'(i_cfg_data);
        if (eff < 2) eff = 2;
        if (eff > MAX_GRID) eff = MAX_GRID;
        n_last = XW'(eff - 1);
    end

    always_comb begin
        if (r_state == F_IDLE) begin
            w_addr = fn_addr(w_ws, w_wx);
        end else begin
            unique case (r_rc)
                NB_P:    w_addr = fn_addr(r_so, r_xo);
                NB_R:    w_addr = fn_addr(r_so, w_xr);
                NB_L:    w_addr = fn_addr(r_so, w_xl);
                NB_D:    w_addr = fn_addr(w_sd, r_xo);
                NB_U:    w_addr = fn_addr(w_su, r_xo);
                default: w_addr = fn_addr(r_so, r_xo);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vert && !w_cfg) begin
            r_mem[w_addr] <= '{x: i_in.pos_x, y: i_in.pos_y, z: i_in.pos_z};
        end
        r_rdata <= r_mem[w_addr];
        if (r_state == F_READ && r_rc != NB_P) begin
            r_nb[r_rc - 3'd1] <= r_rdata;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (w_emit && !w_cfg) n_state = F_READ;
            F_READ: if (r_rc == NB_N) n_state = F_PUSH;
            F_PUSH: if (!i_job_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_last  <= XW'(RST_SIZE - 1);
            r_xi <= '0; r_zi <= '0; r_si <= '0; r_fi <= 1'b0;
            r_xo <= '0; r_zo <= '0; r_so <= '0; r_fo <= 1'b0;
            r_rc <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg) begin
                r_last <= n_last;
                r_xi <= '0; r_zi <= '0; r_si <= '0; r_fi <= 1'b0;
                r_xo <= '0; r_zo <= '0; r_so <= '0; r_fo <= 1'b0;
            end else begin
                if (w_vert) begin
                    if (w_wx == r_last) begin
                        r_xi <= '0;
                        if (w_wz == r_last) begin
                            r_zi <= '0; r_si <= 2'd0; r_fi <= 1'b1;
                        end else begin
                            r_zi <= w_wz + 1'b1; r_si <= fn_slot_next(w_ws); r_fi <= 1'b0;
                        end
                    end else begin
                        r_xi <= w_wx + 1'b1; r_zi <= w_wz; r_si <= w_ws; r_fi <= 1'b0;
                    end
                    if (r_fi) begin
                        r_xo <= '0; r_zo <= '0; r_so <= 2'd0; r_fo <= 1'b0;
                    end
                end
                if (o_job_push) begin
                    if (r_xo == r_last) begin
                        r_xo <= '0;
                        if (r_zo == r_last) begin
                            r_zo <= '0; r_so <= 2'd0; r_fo <= 1'b1;
                        end else begin
                            r_zo <= r_zo + 1'b1; r_so <= fn_slot_next(r_so);
                        end
                    end else begin
                        r_xo <= r_xo + 1'b1;
                    end
                end
            end
            if (r_state == F_READ) begin
                r_rc <= r_rc + 3'd1;
            end else begin
                r_rc <= '0;
            end
        end
    end

    assign o_job_push = (r_state == F_PUSH) && !i_job_full;

    always_comb begin
        o_job.p    = r_nb[NB_P];
        o_job.dx.x = 33'(r_nb[NB_R].x) - 33'(r_nb[NB_L].x);
        o_job.dx.y = 33'(r_nb[NB_R].y) - 33'(r_nb[NB_L].y);
        o_job.dx.z = 33'(r_nb[NB_R].z) - 33'(r_nb[NB_L].z);
        o_job.dz.x = 33'(r_nb[NB_D].x) - 33'(r_nb[NB_U].x);
        o_job.dz.y = 33'(r_nb[NB_D].y) - 33'(r_nb[NB_U].y);
        o_job.dz.z = 33'(r_nb[NB_D].z) - 33'(r_nb[NB_U].z);
        o_job.done = (r_xo == r_last) && (r_zo == r_last);
    end

endmodule

/* sv/gvn_back.sv */
// ----------------------------------------------------------------------------
// gvn_back: normal arithmetic
// Reduce, cross product on one shared multiplier, normalize, bit-serial
// square root and three parallel restoring dividers.
// ----------------------------------------------------------------------------
module gvn_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_empty,
    input  gvn_pkg::t_job        i_job,
    output logic                 o_job_pop,
    output logic                 o_res_push,
    output gvn_pkg::t_out_item   o_res,
    input  logic                 i_res_full
);
    typedef enum logic [8:0] {
        B_IDLE = 9'b000000001,
        B_MUL  = 9'b000000010,
        B_MAG  = 9'b000000100,
        B_NORM = 9'b000001000,
        B_SQR  = 9'b000010000,
        B_SQRT = 9'b000100000,
        B_DSET = 9'b001000000,
        B_DIV  = 9'b010000000,
        B_OUT  = 9'b100000000
    } t_back_state;

    localparam logic [61:0] LIM_HI  = 62'd1 << 30;
    localparam logic [61:0] LIM_HI8 = 62'd1 << 38;
    localparam logic [61:0] LIM_LO  = 62'd1 << 29;
    localparam logic [61:0] LIM_LO8 = 62'd1 << 21;

    function automatic logic signed [30:0] fn_shrink(input logic signed [32:0] v,
                                                     input logic [1:0] sh);
        logic [32:0] m;
        logic [30:0] s;
        m = v[32] ? 33'(-v) : 33'(v);
        s = 31'(m >> sh);
        return v[32] ? -$signed(s) : $signed(s);
    endfunction

    function automatic gvn_pkg::t_vec31 fn_reduce(input gvn_pkg::t_vec33 d);
        logic [32:0] mx, my, mz, mm;
        logic [1:0]  sh;
        gvn_pkg::t_vec31 r;
        mx = d.x[32] ? 33'(-d.x) : 33'(d.x);
        my = d.y[32] ? 33'(-d.y) : 33'(d.y);
        mz = d.z[32] ? 33'(-d.z) : 33'(d.z);
        mm = mx;
        if (my > mm) mm = my;
        if (mz > mm) mm = mz;
        if (mm[32])      sh = 2'd3;
        else if (mm[31]) sh = 2'd2;
        else if (mm[30]) sh = 2'd1;
        else             sh = 2'd0;
        r.x = fn_shrink(d.x, sh);
        r.y = fn_shrink(d.y, sh);
        r.z = fn_shrink(d.z, sh);
        return r;
    endfunction

    t_back_state        r_state;
    gvn_pkg::t_pos      r_p;
    logic               r_done, r_degen;
    gvn_pkg::t_vec31    r_a, r_b;
    logic [5:0]         r_k;
    logic signed [61:0] r_prod;
    logic signed [62:0] r_c [3];
    logic [61:0]        r_m [3];
    logic               r_neg [3];
    logic [61:0]        r_mx;
    logic [63:0]        r_sum, r_v, r_res, r_bit;
    logic [45:0]        r_rem [3];
    logic [44:0]        r_ds;
    logic [14:0]        r_q [3];

    logic signed [30:0] w_op1, w_op2;
    logic signed [61:0] w_prod;
    logic [29:0]        w_sq_in;
    logic [59:0]        w_sq;
    logic [63:0]        w_trial;
    logic [61:0]        w_mag [3];
    logic [61:0]        w_mmax;

    // cross term schedule: c0 = by*az - bz*ay..., pairs per component, minuend first
    always_comb begin
        unique case (r_k[2:0])
            3'd0:    begin w_op1 = r_b.y; w_op2 = r_a.z; end
            3'd1:    begin w_op1 = r_b.z; w_op2 = r_a.y; end
            3'd2:    begin w_op1 = r_b.z; w_op2 = r_a.x; end
            3'd3:    begin w_op1 = r_b.x; w_op2 = r_a.z; end
            3'd4:    begin w_op1 = r_b.x; w_op2 = r_a.y; end
            3'd5:    begin w_op1 = r_b.y; w_op2 = r_a.x; end
            default: begin w_op1 = '0; w_op2 = '0; end
        endcase
    end
    assign w_prod = w_op1 * w_op2;

    always_comb begin
        unique case (r_k[1:0])
            2'd0:    w_sq_in = r_m[0][29:0];
            2'd1:    w_sq_in = r_m[1][29:0];
            2'd2:    w_sq_in = r_m[2][29:0];
            default: w_sq_in = '0;
        endcase
    end
    assign w_sq    = w_sq_in * w_sq_in;
    assign w_trial = r_res + r_bit;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_c[i][62] ? 62'(-r_c[i]) : 62'(r_c[i]);
        end
        w_mmax = w_mag[0];
        if (w_mag[1] > w_mmax) w_mmax = w_mag[1];
        if (w_mag[2] > w_mmax) w_mmax = w_mag[2];
    end

    assign o_job_pop  = (r_state == B_IDLE) && !i_job_empty;
    assign o_res_push = (r_state == B_OUT) && !i_res_full;

    always_comb begin
        o_res.out_x      = r_p.x;
        o_res.out_y      = r_p.y;
        o_res.out_z      = r_p.z;
        o_res.normal_x   = r_degen ? '0 : (r_neg[0] ? -$signed({1'b0, r_q[0]}) : $signed({1'b0, r_q[0]}));
        o_res.normal_y   = r_degen ? '0 : (r_neg[1] ? -$signed({1'b0, r_q[1]}) : $signed({1'b0, r_q[1]}));
        o_res.normal_z   = r_degen ? '0 : (r_neg[2] ? -$signed({1'b0, r_q[2]}) : $signed({1'b0, r_q[2]}));
        o_res.degenerate = r_degen;
        o_res.grid_done  = r_done;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_p    <= i_job.p;
                r_done <= i_job.done;
                r_a    <= fn_reduce(i_job.dx);
                r_b    <= fn_reduce(i_job.dz);
            end
            B_MUL: begin
                r_prod <= w_prod;
                unique case (r_k)
                    6'd1:    r_c[0] <= 63'(r_prod);
                    6'd2:    r_c[0] <= r_c[0] - 63'(r_prod);
                    6'd3:    r_c[1] <= 63'(r_prod);
                    6'd4:    r_c[1] <= r_c[1] - 63'(r_prod);
                    6'd5:    r_c[2] <= 63'(r_prod);
                    6'd6:    r_c[2] <= r_c[2] - 63'(r_prod);
                    default: ;
                endcase
            end
            B_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]   <= w_mag[i];
                    r_neg[i] <= r_c[i][62];
                end
                r_mx  <= w_mmax;
                r_sum <= '0;
            end
            B_NORM: begin
                // coarse steps while far from the window, then single bits
                priority if (r_mx >= LIM_HI8) begin
                    r_mx <= r_mx >> 8;
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 8;
                end else if (r_mx >= LIM_HI) begin
                    r_mx <= r_mx >> 1;
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                end else if (r_mx < LIM_LO8) begin
                    r_mx <= r_mx << 8;
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 8;
                end else if (r_mx < LIM_LO) begin
                    r_mx <= r_mx << 1;
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                end else begin
                    r_mx <= r_mx;
                end
            end
            B_SQR: begin
                if (r_k != 6'd3) begin
                    r_sum <= r_sum + 64'(w_sq);
                end
                r_v   <= r_sum;
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            B_SQRT: begin
                if (r_v >= w_trial) begin
                    r_v   <= r_v - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            B_DSET: begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= {2'b00, r_m[i][29:0], 14'd0} + 46'(r_res[30:1]);
                    r_q[i]   <= '0;
                end
                r_ds <= {r_res[30:0], 14'd0};
            end
            B_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_rem[i] >= {1'b0, r_ds}) begin
                        r_rem[i] <= r_rem[i] - {1'b0, r_ds};
                        r_q[i]   <= {r_q[i][13:0], 1'b1};
                    end else begin
                        r_q[i]   <= {r_q[i][13:0], 1'b0};
                    end
                end
                r_ds <= r_ds >> 1;
            end
            B_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_k     <= '0;
            r_degen <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (!i_job_empty) begin
                        r_state <= B_MUL;
                        r_k     <= '0;
                        r_degen <= 1'b0;
                    end
                end
                B_MUL: begin
                    if (r_k == 6'd6) begin
                        r_state <= B_MAG;
                        r_k     <= '0;
                    end else begin
                        r_k <= r_k + 6'd1;
                    end
                end
                B_MAG: begin
                    if (w_mmax == '0) begin
                        r_degen <= 1'b1;
                        r_state <= B_OUT;
                    end else begin
                        r_state <= B_NORM;
                    end
                end
                B_NORM: begin
                    if (r_mx >= LIM_LO && r_mx < LIM_HI) begin
                        r_state <= B_SQR;
                        r_k     <= '0;
                    end
                end
                B_SQR: begin
                    if (r_k == 6'd3) begin
                        r_state <= B_SQRT;
                        r_k     <= '0;
                    end else begin
                        r_k <= r_k + 6'd1;
                    end
                end
                B_SQRT: begin
                    if (r_bit == 64'd1) r_state <= B_DSET;
                end
                B_DSET: begin
                    r_state <= B_DIV;
                    r_k     <= '0;
                end
                B_DIV: begin
                    if (r_k == 6'd14) begin
                        r_state <= B_OUT;
                    end else begin
                        r_k <= r_k + 6'd1;
                    end
                end
                B_OUT: begin
                    if (!i_res_full) r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

/* sv/grid_vertex_normal_generator.sv */
// ----------------------------------------------------------------------------
// grid_vertex_normal_generator: heightfield vertex normals by central difference
// Streams a square grid of Q16.16 vertices and returns position plus Q1.14 normal.
// ----------------------------------------------------------------------------
// Push the grid in row order (cmd = vertex). The result for a vertex appears
// once the vertex one row below it has arrived; after the last vertex, push one
// drain item per last-row result. A vertex pushed while last-row results are
// still pending is dropped, and a vertex after a fully drained grid starts a
// new one. Writing grid_size (clamped to 2..MAX_GRID) restarts the grid; write
// it only when the block is idle. The normal is normalize(cross(dz, dx)) with
// edge-clamped neighbors; a zero cross product gives a zero normal and sets
// degenerate. grid_done marks the result of the last grid vertex.
//
// Timing: an item that releases a result makes the front read five neighbors
// through the single port of the 3*MAX_GRID row store. The back works one
// result at a time through the 32-step square root, the 15-step division, the
// six-product cross on one multiplier and the normalizing shifts; a degenerate
// one goes from the magnitude step straight to output. A two-entry queue
// between front and back, and another on the result side, let intake run ahead
// of the arithmetic. Items that release no result are taken at one per cycle
// while the front is not busy with a gather. The row store needs no clearing
// after reset.
// ----------------------------------------------------------------------------
module grid_vertex_normal_generator #(
    parameter int MAX_GRID = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [gvn_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_push,
    output logic                      o_full,
    input  gvn_pkg::t_in_item         i_in,
    output logic                      o_empty,
    input  logic                      i_pop,
    output gvn_pkg::t_out_item        o_out
);
    localparam int JW = $bits(gvn_pkg::t_job);
    localparam int OW = $bits(gvn_pkg::t_out_item);

    gvn_pkg::t_job      w_job_in, w_job_out;
    gvn_pkg::t_out_item w_res;
    logic               w_job_push, w_job_full, w_job_pop, w_job_empty;
    logic               w_res_push, w_res_full;
    logic [JW-1:0]      w_job_bits;
    logic [OW-1:0]      w_out_bits;

    // front: intake, row store, neighbor gather
    gvn_front #(
        .MAX_GRID (MAX_GRID)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_in        (i_in),
        .o_job_push  (w_job_push),
        .o_job       (w_job_in),
        .i_job_full  (w_job_full)
    );

    // hold gathered jobs so the front can take the next item
    gvn_fifo #(
        .W     (JW),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_bits),
        .o_empty (w_job_empty)
    );
    assign w_job_out = gvn_pkg::t_job'(w_job_bits);

    // back: normal arithmetic
    gvn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    // result queue: the back moves on while a result waits to be popped
    gvn_fifo #(
        .W     (OW),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_data  (w_out_bits),
        .o_empty (o_empty)
    );
    assign o_out = gvn_pkg::t_out_item'(w_out_bits);

endmodule

/* sv/gvn_checker.sv */
// ----------------------------------------------------------------------------
// gvn_checker: port-level checks of the grid vertex normal generator
// Bound to the top level.
// ----------------------------------------------------------------------------
module gvn_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_full,
    input logic               o_empty,
    input logic               i_pop,
    input gvn_pkg::t_out_item o_out
);
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("intake blocked after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out)))
        else $error("waiting item changed or vanished");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.degenerate) |->
        (o_out.normal_x == 16'sd0 && o_out.normal_y == 16'sd0 && o_out.normal_z == 16'sd0))
        else $error("degenerate item with nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |->
        (o_out.normal_x <= 16'sd16384 && o_out.normal_x >= -16'sd16384 &&
         o_out.normal_y <= 16'sd16384 && o_out.normal_y >= -16'sd16384 &&
         o_out.normal_z <= 16'sd16384 && o_out.normal_z >= -16'sd16384))
        else $error("normal component out of unit range");

endmodule

bind grid_vertex_normal_generator gvn_checker u_gvn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_full  (o_full),
    .o_empty (o_empty),
    .i_pop   (i_pop),
    .o_out   (o_out)
);
